// ----- rtl/core/response_frame_checker_defines.svh -----
// Assertion macros shared by the response frame checker RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define RFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rfc_pkg.sv -----
// Types, codes and helper functions of the response frame checker.
// No dependencies; imported by every module of the block.
package rfc_pkg;

  typedef enum logic [1:0] {
    MODE_BROADCAST = 2'd0,
    MODE_FRAMED    = 2'd1,
    MODE_OTHER     = 2'd2
  } rfc_mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_MALFORM  = 3'd2,
    ST_WRONG_SRC = 3'd3,
    ST_BAD_SUM  = 3'd4
  } rfc_status_e;

  localparam logic [7:0] SRC_BROADCAST = 8'h00;
  localparam logic [7:0] SRC_FRAMED_A  = 8'h26;
  localparam logic [7:0] SRC_FRAMED_B  = 8'h27;
  localparam logic [7:0] SRC_FRAMED_C  = 8'h30;
  localparam logic [7:0] START_RESET   = 8'h35;
  localparam logic [7:0] MIN_FRAME     = 8'd5;
  localparam logic [7:0] FIRST_PAYLOAD = 8'd3;
  localparam int unsigned FIFO_DEPTH   = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       last;
    logic [7:0] expected_source;
  } rfc_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] payload_count;
    logic       out_last;
  } rfc_result_t;

  // Up to two results per item, first one in res0.
  typedef struct packed {
    logic        valid0;
    logic        valid1;
    rfc_result_t res0;
    rfc_result_t res1;
  } rfc_push_t;

  function automatic rfc_mode_e mode_of(input logic [7:0] src);
    if (src == SRC_BROADCAST) begin
      return MODE_BROADCAST;
    end
    if (src == SRC_FRAMED_A || src == SRC_FRAMED_B || src == SRC_FRAMED_C) begin
      return MODE_FRAMED;
    end
    return MODE_OTHER;
  endfunction

  function automatic rfc_status_e frame_status(
    input rfc_mode_e  mode,
    input logic [7:0] cnt,
    input logic [7:0] first,
    input logic [7:0] srcb,
    input logic [7:0] latched,
    input logic [7:0] len,
    input logic [7:0] xsum,
    input logic [7:0] start
  );
    rfc_status_e st;
    st = ST_OK;
    case (mode)
      MODE_BROADCAST: begin
        st = (cnt == 8'd0) ? ST_BAD_LEN : ST_OK;
      end
      MODE_FRAMED: begin
        if (cnt < MIN_FRAME)         st = ST_BAD_LEN;
        else if (first != start)     st = ST_MALFORM;
        else if (srcb != latched)    st = ST_WRONG_SRC;
        else if (len != cnt)         st = ST_BAD_LEN;
        else if (xsum != 8'd0)       st = ST_BAD_SUM;
        else                         st = ST_OK;
      end
      default: begin
        st = ST_OK;
      end
    endcase
    return st;
  endfunction

endpackage

// ----- rtl/core/rfc_frame_core.sv -----
// Per-frame state and checking logic: takes one item per fire, builds up to two results.
// Depends on rfc_pkg.
module rfc_frame_core import rfc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  rfc_item_t  item_i,
  input  logic [7:0] start_byte_i,
  output rfc_push_t  push_o
);

  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] first_q, first_d;
  logic [7:0] srcb_q, srcb_d;
  logic [7:0] len_q, len_d;
  rfc_mode_e  mode_q, mode_d;
  logic [7:0] latched_q, latched_d;
  logic [7:0] emit_q, emit_d;

  logic [7:0] max_bytes;
  assign max_bytes = MAX_FRAME_BYTES[7:0];

  always_comb begin
    rfc_result_t pay_res;
    rfc_result_t st_res;
    logic        take;
    logic        payload;
    logic        done;
    rfc_mode_e   mode_end;

    cnt_d     = cnt_q;
    xor_d     = xor_q;
    first_d   = first_q;
    srcb_d    = srcb_q;
    len_d     = len_q;
    mode_d    = mode_q;
    latched_d = latched_q;
    emit_d    = emit_q;
    payload   = 1'b0;
    take      = 1'b0;
    mode_end  = mode_q;

    if (item_i.func) begin
      // Reply ended: a reply with no bytes takes its mode from the source now.
      if (cnt_q == 8'd0) begin
        mode_end = mode_of(item_i.expected_source);
      end
    end else begin
      take = (cnt_q < max_bytes);
      if (take) begin
        if (cnt_q == 8'd0) begin
          latched_d = item_i.expected_source;
          mode_d    = mode_of(item_i.expected_source);
          first_d   = item_i.rx_byte;
        end else if (cnt_q == 8'd1) begin
          srcb_d = item_i.rx_byte;
        end else if (cnt_q == 8'd2) begin
          len_d = item_i.rx_byte;
        end
        xor_d = xor_q ^ item_i.rx_byte;
        cnt_d = cnt_q + 8'd1;
        case (mode_d)
          MODE_BROADCAST: payload = 1'b1;
          MODE_FRAMED: begin
            payload = (cnt_q >= FIRST_PAYLOAD) &&
                      (({1'b0, cnt_q} + 9'd2) <= {1'b0, len_d});
          end
          default: payload = 1'b0;
        endcase
        if (payload) begin
          emit_d = emit_q + 8'd1;
        end
      end
      mode_end = mode_d;
    end

    done = item_i.func || item_i.last;

    pay_res.out_kind      = 1'b0;
    pay_res.payload_byte  = item_i.rx_byte;
    pay_res.status        = ST_OK;
    pay_res.payload_count = emit_d;
    pay_res.out_last      = 1'b0;

    st_res.out_kind      = 1'b1;
    st_res.payload_byte  = 8'd0;
    st_res.status        = frame_status(mode_end, cnt_d, first_d, srcb_d, latched_d,
                                        len_d, xor_d, start_byte_i);
    st_res.payload_count = emit_d;
    st_res.out_last      = 1'b1;

    if (payload) begin
      push_o.valid0 = fire_i;
      push_o.res0   = pay_res;
      push_o.valid1 = fire_i && done;
      push_o.res1   = st_res;
    end else begin
      push_o.valid0 = fire_i && done;
      push_o.res0   = st_res;
      push_o.valid1 = 1'b0;
      push_o.res1   = st_res;
    end

    // Drop all frame state once the status goes out.
    if (done) begin
      cnt_d     = 8'd0;
      xor_d     = 8'd0;
      first_d   = 8'd0;
      srcb_d    = 8'd0;
      len_d     = 8'd0;
      mode_d    = MODE_BROADCAST;
      latched_d = 8'd0;
      emit_d    = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 8'd0;
      xor_q     <= 8'd0;
      first_q   <= 8'd0;
      srcb_q    <= 8'd0;
      len_q     <= 8'd0;
      mode_q    <= MODE_BROADCAST;
      latched_q <= 8'd0;
      emit_q    <= 8'd0;
    end else if (fire_i) begin
      cnt_q     <= cnt_d;
      xor_q     <= xor_d;
      first_q   <= first_d;
      srcb_q    <= srcb_d;
      len_q     <= len_d;
      mode_q    <= mode_d;
      latched_q <= latched_d;
      emit_q    <= emit_d;
    end
  end

endmodule

// ----- rtl/core/rfc_out_fifo.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on rfc_pkg.
module rfc_out_fifo import rfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rfc_push_t   push_i,
  input  logic        pop_i,
  output rfc_result_t head_o,
  output logic        valid_o,
  output logic [$clog2(FIFO_DEPTH):0] level_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  rfc_result_t         mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [PtrW:0]       lvl_q, lvl_d;
  logic [PtrW-1:0]     wr_next;

  assign wr_next = wr_q + 1'b1;

  always_comb begin
    logic [PtrW:0] n_push;
    n_push = {{PtrW{1'b0}}, push_i.valid0} + {{PtrW{1'b0}}, push_i.valid1};
    wr_d   = wr_q + n_push[PtrW-1:0];
    rd_d   = pop_i ? rd_q + 1'b1 : rd_q;
    lvl_d  = lvl_q + n_push - {{PtrW{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.valid1) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (lvl_q != '0);
  assign level_o = lvl_q;

endmodule

// ----- rtl/core/response_frame_checker.sv -----
// Top level of the response frame checker: input register, frame core, result queue.
// Depends on rfc_pkg, rfc_frame_core, rfc_out_fifo and response_frame_checker_defines.svh.
//
//  Channel   Dir  Handshake                  Contents
//  s_axis    in   tvalid/tready              tdata {expected_source, rx_byte}, tuser func,
//                                            tlast last
//  m_axis    out  tvalid/tready              tdata {count, status, payload_byte},
//                                            tuser out_kind, tlast out_last
//  cfg       in   cfg_we_i (no wait)         cfg_wdata_i = start_byte
//
// One item a cycle while the result queue has room for two results: an accepted item
// is held in the input register, then checked and pushed into the four-entry result
// queue, whose head drives m_axis. An item that ends a frame with a payload byte yields
// two results; the queue pace sets the rate.
// Reset is asynchronous and clears all frame state; start_byte returns to 0x35.
// No clearing pass. A stall on m_axis fills the queue until it lacks room for two results,
// then the input register, then drops s_axis_tready_o.
`include "response_frame_checker_defines.svh"

module response_frame_checker import rfc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: start byte
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // byte stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] rx_byte, [15:8] expected_source
  input  logic        s_axis_tuser_i,  // [0] func
  input  logic        s_axis_tlast_i,  // last
  // results out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] payload_byte, [10:8] status,
                                       // [18:11] payload_count, [23:19] zero
  output logic        m_axis_tuser_o,  // [0] out_kind
  output logic        m_axis_tlast_o   // out_last
);

  localparam int unsigned LvlW = $clog2(FIFO_DEPTH) + 1;

  logic        start_q;
  logic [7:0]  start_byte_q;
  logic        in_valid_q;
  rfc_item_t   in_item_q;
  logic        fire;
  logic        s_accept;
  rfc_push_t   push;
  rfc_result_t head;
  logic        head_valid;
  logic        pop;
  logic [LvlW-1:0] level;

  // Hold the start byte; it must be written only while idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_RESET;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  // Advance the held item once the queue has room for two results.
  assign fire            = in_valid_q && (level <= LvlW'(FIFO_DEPTH - 2));
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      start_q    <= 1'b0;
    end else begin
      in_valid_q <= s_accept || (in_valid_q && !fire);
      start_q    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.func            <= s_axis_tuser_i;
      in_item_q.rx_byte         <= s_axis_tdata_i[7:0];
      in_item_q.last            <= s_axis_tlast_i;
      in_item_q.expected_source <= s_axis_tdata_i[15:8];
    end
  end

  rfc_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_item_q),
    .start_byte_i (start_byte_q),
    .push_o       (push)
  );

  assign pop = head_valid && m_axis_tready_i;

  rfc_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .level_o (level)
  );

  assign m_axis_tvalid_o = head_valid;
  assign m_axis_tdata_o  = {5'd0, head.payload_count, head.status, head.payload_byte};
  assign m_axis_tuser_o  = head.out_kind;
  assign m_axis_tlast_o  = head.out_last;

  // Assertions
  `RFC_ASSERT_IMP(a_kind_is_last, m_axis_tvalid_o, m_axis_tuser_o == m_axis_tlast_o, "status result must carry last and only it")
  `RFC_ASSERT_IMP(a_payload_no_status, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[10:8] == ST_OK, "payload result with nonzero status")
  `RFC_ASSERT_IMP(a_status_range, m_axis_tvalid_o, m_axis_tdata_o[10:8] <= ST_BAD_SUM, "status code out of range")
  `RFC_ASSERT(a_queue_bound, level <= LvlW'(FIFO_DEPTH), "result queue overfilled")
  `RFC_ASSERT_NXT(a_item_held, start_q && in_valid_q && !fire, in_valid_q && $stable(in_item_q), "held item lost while queue full")
  `RFC_ASSERT_IMP(a_second_needs_first, push.valid1, push.valid0 && fire, "second result pushed without first")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for response_frame_checker: bytes and end events stream in,
// payload and frame verdicts stream out. Depends on rfc_pkg and the checker RTL.
module tb_top;
  import rfc_pkg::*;

  localparam int MAX_FRAME_BYTES = 255;
  localparam int DRAIN_CYCLES    = 8;     // input register + core + queue, with margin
  localparam int HOLD_CYCLES     = 300;   // long output hold-off to back up the block
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int PRINT_CAP       = 40;

  // Defects injected into otherwise good framed replies.
  typedef enum int {
    FLAW_SHORT, FLAW_START, FLAW_SOURCE, FLAW_LENGTH, FLAW_SUM, FLAW_CUT
  } frame_flaw_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  logic       s_valid  = 1'b0;
  rfc_item_t  drv_item = '0;
  logic       s_ready;

  logic        m_ready = 1'b0;
  logic        m_valid;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Items waiting for the driver, and results the checker owes us.
  rfc_item_t   rx_stream_q[$];
  rfc_result_t frame_results_q[$];
  logic [7:0]  frame_bytes[$];

  // Shadow of the frame state, tracked per accepted item.
  logic [7:0] fm_count   = '0;
  logic [7:0] fm_xor     = '0;
  logic [7:0] fm_first   = '0;
  logic [7:0] fm_srcb    = '0;
  logic [7:0] fm_len     = '0;
  rfc_mode_e  fm_mode    = MODE_BROADCAST;
  logic [7:0] fm_latched = '0;
  logic [7:0] fm_emitted = '0;
  logic [7:0] start_now  = START_RESET;

  int send_idle_pct  = 13;
  int recv_stall_pct = 58;
  bit pressure_armed = 1'b0;
  bit pressure_done  = 1'b0;
  int hold_count     = 0;

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int verdict_tally[5];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  response_frame_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i ({drv_item.expected_source, drv_item.rx_byte}),
    .s_axis_tuser_i (drv_item.func),
    .s_axis_tlast_i (drv_item.last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Classify the latched controller address.
  function automatic rfc_mode_e source_mode(input logic [7:0] src);
    rfc_mode_e m;
    case (src)
      SRC_BROADCAST:                            m = MODE_BROADCAST;
      SRC_FRAMED_A, SRC_FRAMED_B, SRC_FRAMED_C: m = MODE_FRAMED;
      default:                                  m = MODE_OTHER;
    endcase
    return m;
  endfunction

  // Verdict on the frame just ended; the framed checks run in priority order.
  function automatic rfc_status_e judge_frame();
    rfc_status_e verdict;
    verdict = ST_OK;
    if (fm_mode == MODE_BROADCAST) begin
      if (fm_count == 8'd0) verdict = ST_BAD_LEN;
    end else if (fm_mode == MODE_FRAMED) begin
      if (fm_count < MIN_FRAME)          verdict = ST_BAD_LEN;
      else if (fm_first != start_now)    verdict = ST_MALFORM;
      else if (fm_srcb != fm_latched)    verdict = ST_WRONG_SRC;
      else if (fm_len != fm_count)       verdict = ST_BAD_LEN;
      else if (fm_xor != 8'd0)           verdict = ST_BAD_SUM;
    end
    return verdict;
  endfunction

  // Emit the end-of-frame status and forget the frame.
  task automatic close_frame();
    rfc_result_t r;
    rfc_status_e verdict;
    verdict         = judge_frame();
    r.out_kind      = 1'b1;
    r.payload_byte  = 8'h00;
    r.status        = verdict;
    r.payload_count = fm_emitted;
    r.out_last      = 1'b1;
    frame_results_q.push_back(r);
    verdict_tally[int'(verdict)]++;
    fm_count   = '0;
    fm_xor     = '0;
    fm_first   = '0;
    fm_srcb    = '0;
    fm_len     = '0;
    fm_mode    = MODE_BROADCAST;
    fm_latched = '0;
    fm_emitted = '0;
  endtask

  // Advance the shadow state by one accepted item and queue what it yields.
  task automatic advance_frame_model(input rfc_item_t it);
    logic [7:0]  pos;
    bit          payload;
    rfc_result_t r;
    if (it.func) begin
      // An end with nothing received takes its mode from the address on the item.
      if (fm_count == 8'd0) fm_mode = source_mode(it.expected_source);
      close_frame();
    end else begin
      if (int'(fm_count) < MAX_FRAME_BYTES) begin
        pos = fm_count;
        if (pos == 8'd0) begin
          fm_latched = it.expected_source;
          fm_mode    = source_mode(it.expected_source);
          fm_first   = it.rx_byte;
        end else if (pos == 8'd1) begin
          fm_srcb = it.rx_byte;
        end else if (pos == 8'd2) begin
          fm_len = it.rx_byte;
        end
        fm_xor   = fm_xor ^ it.rx_byte;
        fm_count = pos + 8'd1;
        payload  = (fm_mode == MODE_BROADCAST) ||
                   (fm_mode == MODE_FRAMED && pos >= FIRST_PAYLOAD &&
                    int'(pos) + 2 <= int'(fm_len));
        if (payload) begin
          fm_emitted      = fm_emitted + 8'd1;
          r.out_kind      = 1'b0;
          r.payload_byte  = it.rx_byte;
          r.status        = ST_OK;
          r.payload_count = fm_emitted;
          r.out_last      = 1'b0;
          frame_results_q.push_back(r);
        end
      end
      // A last mark ends the reply even on a byte past the length limit.
      if (it.last) close_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reply builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] framed_source();
    logic [7:0] src;
    case ($urandom_range(2))
      0:       src = SRC_FRAMED_A;
      1:       src = SRC_FRAMED_B;
      default: src = SRC_FRAMED_C;
    endcase
    return src;
  endfunction

  function automatic logic [7:0] other_source();
    logic [7:0] src;
    src = 8'($urandom);
    while (source_mode(src) != MODE_OTHER) src = 8'($urandom);
    return src;
  endfunction

  // Fill frame_bytes with a well-formed framed reply of len bytes.
  task automatic fill_good_frame(input logic [7:0] src, input int len);
    logic [7:0] sum;
    sum = 8'h00;
    frame_bytes.delete();
    frame_bytes.push_back(start_now);
    frame_bytes.push_back(src);
    frame_bytes.push_back(8'(len));
    for (int i = 3; i < len - 1; i++) frame_bytes.push_back(8'($urandom));
    foreach (frame_bytes[i]) sum = sum ^ frame_bytes[i];
    frame_bytes.push_back(sum);
  endtask

  task automatic fill_random_bytes(input int n);
    frame_bytes.delete();
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic trim_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endtask

  // Turn frame_bytes into items: the source rides on the first byte only, later
  // bytes carry noise there. End either with a last mark or with an end event.
  task automatic queue_reply(input logic [7:0] src, input bit end_by_event);
    rfc_item_t it;
    foreach (frame_bytes[i]) begin
      it.func            = 1'b0;
      it.rx_byte         = frame_bytes[i];
      it.last            = !end_by_event && (i == frame_bytes.size() - 1);
      it.expected_source = (i == 0) ? src : 8'($urandom);
      rx_stream_q.push_back(it);
    end
    if (end_by_event) begin
      it.func            = 1'b1;
      it.rx_byte         = 8'($urandom);
      it.last            = 1'($urandom);
      it.expected_source = (frame_bytes.size() == 0) ? src : 8'($urandom);
      rx_stream_q.push_back(it);
    end
    items_queued += frame_bytes.size() + (end_by_event ? 1 : 0);
    frame_bytes.delete();
  endtask

  // Mostly framed replies, some carrying one defect; the rest are broadcast,
  // unchecked or empty replies.
  task automatic queue_random_reply();
    int          pick;
    int          len;
    logic [7:0]  src;
    bit          cut;
    frame_flaw_e flaw;
    pick = $urandom_range(99);
    cut  = 1'b0;
    len  = ($urandom_range(19) == 0) ? $urandom_range(17, 60) : $urandom_range(5, 16);
    if (pick < 70) begin
      src = framed_source();
      fill_good_frame(src, len);
      if (pick >= 45) begin
        flaw = frame_flaw_e'($urandom_range(5));
        case (flaw)
          FLAW_SHORT:  trim_frame($urandom_range(1, 4));
          FLAW_START:  frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
          FLAW_SOURCE: frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
          FLAW_LENGTH: frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
          FLAW_SUM: begin
            frame_bytes[len-1] = frame_bytes[len-1] ^ 8'($urandom_range(1, 255));
          end
          default: begin
            trim_frame($urandom_range(1, len));
            cut = 1'b1;
          end
        endcase
      end
    end else if (pick < 90) begin
      src = (pick < 82) ? SRC_BROADCAST : other_source();
      fill_random_bytes($urandom_range(1, 8));
      cut = ($urandom_range(3) == 0);
    end else begin
      // No reply at all.
      case ($urandom_range(2))
        0:       src = SRC_BROADCAST;
        1:       src = framed_source();
        default: src = 8'($urandom);
      endcase
      cut = 1'b1;
    end
    queue_reply(src, cut);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued items, advance the predictor on each handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        advance_frame_model(drv_item);
        items_accepted++;
      end
      // Hold the item until taken; otherwise offer the next one or idle.
      if (!s_valid || s_ready) begin
        if (rx_stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item <= rx_stream_q.pop_front();
          s_valid  <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, plus one long hold-off when armed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (pressure_armed && !pressure_done) begin
      m_ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) pressure_done = 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
               $time, results_seen, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    rfc_result_t seen;
    rfc_result_t want;
    if (rst_n && m_valid && m_ready) begin
      seen.out_kind      = m_tuser;
      seen.payload_byte  = m_tdata[7:0];
      seen.status        = m_tdata[10:8];
      seen.payload_count = m_tdata[18:11];
      seen.out_last      = m_tlast;
      if (frame_results_q.size() == 0) begin
        report_mismatch("result with nothing pending, data", 0, m_tdata);
      end else begin
        want = frame_results_q.pop_front();
        if (seen.out_kind != want.out_kind)
          report_mismatch("out_kind", want.out_kind, seen.out_kind);
        if (seen.payload_byte != want.payload_byte)
          report_mismatch("payload_byte", want.payload_byte, seen.payload_byte);
        if (seen.status != want.status)
          report_mismatch("status", want.status, seen.status);
        if (seen.payload_count != want.payload_count)
          report_mismatch("payload_count", want.payload_count, seen.payload_count);
        if (seen.out_last != want.out_last)
          report_mismatch("out_last", want.out_last, seen.out_last);
      end
      if (m_tdata[23:19] != 5'd0) report_mismatch("tdata padding", 0, m_tdata[23:19]);
      results_seen++;
    end
  end

  // Watchdog: end the run when neither side has moved an item for too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                 idle_cycles, frame_results_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // Wait until every item is in and every result is out, then let the
  // pipeline run empty (items that yield nothing may still be in flight).
  task automatic wait_for_quiet();
    do @(negedge clk_i);
    while (rx_stream_q.size() != 0 || s_valid || frame_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] new_start;
    int         phase_goal;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        // Change the start byte only between whole replies with the block idle.
        wait_for_quiet();
        case (phase)
          1:       new_start = 8'h00;
          2:       new_start = 8'hFF;
          default: new_start = 8'($urandom);
        endcase
        @(posedge clk_i);
        cfg_we    <= 1'b1;
        cfg_wdata <= new_start;
        start_now  = new_start;
        @(posedge clk_i);
        cfg_we <= 1'b0;
        @(negedge clk_i);
      end

      case (phase)
        0: begin
          send_idle_pct  = 13;
          recv_stall_pct = 58;
        end
        1: begin
          send_idle_pct  = 58;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // Empty replies: broadcast and framed report bad length, others pass.
        queue_reply(SRC_BROADCAST, 1'b1);
        queue_reply(SRC_FRAMED_A, 1'b1);
        queue_reply(8'h55, 1'b1);
        // Smallest good frame, one payload byte at the top of the range.
        fill_good_frame(SRC_FRAMED_B, 5);
        frame_bytes[3] = 8'hFF;
        frame_bytes[4] = frame_bytes[0] ^ frame_bytes[1] ^ frame_bytes[2] ^ 8'hFF;
        queue_reply(SRC_FRAMED_B, 1'b0);
        // Broadcast whose last byte is also payload: payload then status.
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        queue_reply(SRC_BROADCAST, 1'b0);
        // Wrong start byte.
        fill_good_frame(SRC_FRAMED_C, 5);
        frame_bytes[0] = 8'h00;
        queue_reply(SRC_FRAMED_C, 1'b0);
        // Reply cut short by an end event after three bytes.
        fill_good_frame(SRC_FRAMED_A, 6);
        trim_frame(3);
        queue_reply(SRC_FRAMED_A, 1'b1);
        // Unchecked source.
        fill_random_bytes(2);
        queue_reply(8'hFF, 1'b0);
        // Overlong reply: bytes past the limit are dropped, its last mark still counts.
        fill_good_frame(SRC_FRAMED_B, 5);
        while (frame_bytes.size() < MAX_FRAME_BYTES + 2) frame_bytes.push_back(8'($urandom));
        queue_reply(SRC_FRAMED_B, 1'b0);
      end

      if (phase == 2) begin
        // Largest legal frame while the output is held off.
        fill_good_frame(framed_source(), MAX_FRAME_BYTES);
        queue_reply(frame_bytes[1], 1'b0);
        pressure_armed = 1'b1;
      end

      phase_goal = items_queued + 200;
      while (items_queued < phase_goal) queue_random_reply();
    end

    wait_for_quiet();

    $display("Covered %0d input items and %0d results; verdicts ok %0d, bad length %0d,",
             items_accepted, results_seen, verdict_tally[0], verdict_tally[1]);
    $display("malformed %0d, wrong source %0d, bad checksum %0d; start byte 0x35/0x00/0xFF/0x%02h",
             verdict_tally[2], verdict_tally[3], verdict_tally[4], start_now);
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
